[rtl/core/nfc_response_frame_deframer_top_assert.svh]
// Assertion macros for the response frame deframer.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef NFC_RESPONSE_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define NFC_RESPONSE_FRAME_DEFRAMER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define NFC_ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NFC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NFC_ASSERT_HOLDS(label, prop, msg)
`define NFC_ASSERT_NEVER(label, cond, msg)
`endif

`endif

[rtl/core/nfc_rfd_pkg.sv]
// Shared types and constants of the response frame deframer.
// No dependencies; used by the parser and the top level.
package nfc_rfd_pkg;

    localparam logic [7:0] PREAMBLE_BYTE = 8'h00;
    localparam logic [7:0] START1_BYTE   = 8'h00;
    localparam logic [7:0] START2_BYTE   = 8'hFF;
    localparam logic [7:0] TFI_BYTE      = 8'hD5;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_HEADER = 3'd1;
    localparam logic [2:0] ST_LENGTH = 3'd2;
    localparam logic [2:0] ST_IDENT  = 3'd3;
    localparam logic [2:0] ST_CSUM   = 3'd4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_end;
        logic [2:0] status;
        logic [7:0] payload_count;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } parser_out_t;

endpackage

[rtl/core/nfc_rfd_if.sv]
// Handshake channel interfaces for received bytes and for results.
// Depends on nothing; one interface per channel type.
interface nfc_rfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface nfc_rfd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_end;
    logic [2:0] status;
    logic [7:0] payload_count;

    modport source (output valid, output payload_byte, output payload_valid,
                    output frame_end, output status, output payload_count, input ready);
    modport sink (input valid, input payload_byte, input payload_valid,
                  input frame_end, input status, input payload_count, output ready);
endinterface

[rtl/core/nfc_rfd_parser.sv]
// Frame parser state machine: one received byte per cycle, registered result.
// Depends on nfc_rfd_pkg.
module nfc_rfd_parser
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     beat_valid,
    input  logic [7:0]               rx_byte,
    input  logic [7:0]               expected_command,
    output nfc_rfd_pkg::parser_out_t result
);

    typedef enum logic [3:0] {
        PH_PRE,
        PH_START1,
        PH_START2,
        PH_LEN,
        PH_LCS,
        PH_TFI,
        PH_CMD,
        PH_DATA,
        PH_DCS,
        PH_POST
    } phase_t;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [7:0]           frame_length_reg;
    logic [7:0]           frame_length_next;
    logic [7:0]           bytes_left_reg;
    logic [7:0]           bytes_left_next;
    logic [7:0]           running_sum_reg;
    logic [7:0]           running_sum_next;
    logic [2:0]           pending_status_reg;
    logic [2:0]           pending_status_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    nfc_rfd_pkg::result_t res_reg;
    nfc_rfd_pkg::result_t res_next;

    logic [7:0] payload_total;
    logic [7:0] sum_with_byte;
    logic [7:0] command_reply;
    logic [7:0] length_check;

    // Payload is the length minus two, saturating at zero.
    assign payload_total = (frame_length_reg >= 8'd2) ? (frame_length_reg - 8'd2) : 8'd0;
    assign sum_with_byte = running_sum_reg + rx_byte;
    assign command_reply = expected_command + 8'd1;
    assign length_check  = frame_length_reg + rx_byte;

    always_comb
    begin
        phase_next          = phase_reg;
        frame_length_next   = frame_length_reg;
        bytes_left_next     = bytes_left_reg;
        running_sum_next    = running_sum_reg;
        pending_status_next = pending_status_reg;
        res_valid_next      = 1'b0;
        res_next            = res_reg;
        if (beat_valid)
        begin
            res_next = '0;
            case (phase_reg)
                PH_START1:
                begin
                    if (rx_byte != nfc_rfd_pkg::START1_BYTE)
                    begin
                        res_valid_next     = 1'b1;
                        res_next.frame_end = 1'b1;
                        res_next.status    = nfc_rfd_pkg::ST_HEADER;
                        phase_next         = PH_PRE;
                    end
                    else
                    begin
                        phase_next = PH_START2;
                    end
                end
                PH_START2:
                begin
                    if (rx_byte != nfc_rfd_pkg::START2_BYTE)
                    begin
                        res_valid_next     = 1'b1;
                        res_next.frame_end = 1'b1;
                        res_next.status    = nfc_rfd_pkg::ST_HEADER;
                        phase_next         = PH_PRE;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    frame_length_next = rx_byte;
                    phase_next        = PH_LCS;
                end
                PH_LCS:
                begin
                    if (length_check != 8'd0)
                    begin
                        res_valid_next     = 1'b1;
                        res_next.frame_end = 1'b1;
                        res_next.status    = nfc_rfd_pkg::ST_LENGTH;
                        phase_next         = PH_PRE;
                    end
                    else
                    begin
                        phase_next = PH_TFI;
                    end
                end
                PH_TFI:
                begin
                    if (rx_byte != nfc_rfd_pkg::TFI_BYTE)
                    begin
                        res_valid_next     = 1'b1;
                        res_next.frame_end = 1'b1;
                        res_next.status    = nfc_rfd_pkg::ST_IDENT;
                        phase_next         = PH_PRE;
                    end
                    else
                    begin
                        running_sum_next = rx_byte;
                        phase_next       = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    if (rx_byte != command_reply)
                    begin
                        res_valid_next     = 1'b1;
                        res_next.frame_end = 1'b1;
                        res_next.status    = nfc_rfd_pkg::ST_IDENT;
                        phase_next         = PH_PRE;
                    end
                    else
                    begin
                        running_sum_next = sum_with_byte;
                        bytes_left_next  = payload_total;
                        phase_next       = (payload_total != 8'd0) ? PH_DATA : PH_DCS;
                    end
                end
                PH_DATA:
                begin
                    running_sum_next       = sum_with_byte;
                    bytes_left_next        = bytes_left_reg - 8'd1;
                    res_valid_next         = 1'b1;
                    res_next.payload_byte  = rx_byte;
                    res_next.payload_valid = 1'b1;
                    if (bytes_left_reg == 8'd1)
                    begin
                        phase_next = PH_DCS;
                    end
                end
                PH_DCS:
                begin
                    pending_status_next = (sum_with_byte == 8'd0) ? nfc_rfd_pkg::ST_OK
                                                                  : nfc_rfd_pkg::ST_CSUM;
                    phase_next          = PH_POST;
                end
                PH_POST:
                begin
                    // The postamble itself is not checked.
                    res_valid_next         = 1'b1;
                    res_next.frame_end     = 1'b1;
                    res_next.status        = pending_status_reg;
                    res_next.payload_count = payload_total;
                    phase_next             = PH_PRE;
                end
                default:
                begin
                    // Waiting for the preamble.
                    if (rx_byte != nfc_rfd_pkg::PREAMBLE_BYTE)
                    begin
                        res_valid_next     = 1'b1;
                        res_next.frame_end = 1'b1;
                        res_next.status    = nfc_rfd_pkg::ST_HEADER;
                        phase_next         = PH_PRE;
                    end
                    else
                    begin
                        phase_next = PH_START1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_PRE;
            frame_length_reg   <= 8'd0;
            bytes_left_reg     <= 8'd0;
            running_sum_reg    <= 8'd0;
            pending_status_reg <= nfc_rfd_pkg::ST_OK;
            res_valid_reg      <= 1'b0;
            res_reg            <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            frame_length_reg   <= frame_length_next;
            bytes_left_reg     <= bytes_left_next;
            running_sum_reg    <= running_sum_next;
            pending_status_reg <= pending_status_next;
            res_valid_reg      <= res_valid_next;
            res_reg            <= res_next;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

endmodule

[rtl/core/nfc_response_frame_deframer_top.sv]
// Response frame deframer: takes one received byte per beat, checks the preamble, start
// codes, length check byte, frame identifier and reply command, forwards each payload byte
// as a result beat and closes every frame with one status beat carrying the payload count.
// A byte is taken in every cycle while the result queue has room: the parser state machine
// handles one byte per cycle and registers its result, which then waits in a queue of
// RESULT_DEPTH entries before it reaches res. rx.ready is registered and falls only when
// the queue, counting a result that may still be coming from the parser, could not take
// another one. With the default depth of four the block keeps one byte per cycle as long
// as the result side takes one beat per cycle. The user must write expected_command
// through cfg_we and cfg_wdata only while the block is idle; the block itself does not
// enforce this. Uses nfc_rfd_pkg, the channel interfaces and the assertion macro header.
`include "nfc_response_frame_deframer_top_assert.svh"

module nfc_response_frame_deframer_top
#(
    parameter int RESULT_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    nfc_rfd_rx_if.sink           rx,
    nfc_rfd_res_if.source        res,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata
);

    localparam int PTR_W = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;
    localparam int CNT_W = $clog2(RESULT_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RESULT_DEPTH - 1);
    localparam logic [CNT_W:0]   DEPTH_W  = (CNT_W + 1)'(RESULT_DEPTH);

    logic [7:0]                 expected_command_reg;
    logic                       rx_ready_reg;
    logic                       rx_ready_next;
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    nfc_rfd_pkg::result_t       mem_reg [RESULT_DEPTH];
    nfc_rfd_pkg::parser_out_t   par_result;
    nfc_rfd_pkg::result_t       head;

    logic rx_fire;
    logic push;
    logic pop;

    assign rx_fire = rx.valid && rx_ready_reg;
    assign push    = par_result.valid;
    assign pop     = res.valid && res.ready;

    assign rx.ready = rx_ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_command_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            expected_command_reg <= cfg_wdata;
        end
    end

    nfc_rfd_parser u_parser
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .beat_valid       (rx_fire),
        .rx_byte          (rx.rx_byte),
        .expected_command (expected_command_reg),
        .result           (par_result)
    );

    // Result queue. A byte accepted now can add at most one result next cycle, so the
    // ready decision reserves a slot for it.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        rx_ready_next = (({1'b0, count_next} + (CNT_W + 1)'(rx_fire)) < DEPTH_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            rx_ready_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            rx_ready_reg <= rx_ready_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : (wr_ptr_reg + PTR_W'(1));
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : (rd_ptr_reg + PTR_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= par_result.data;
        end
    end

    assign head              = mem_reg[rd_ptr_reg];
    assign res.valid         = (count_reg != '0);
    assign res.payload_byte  = head.payload_byte;
    assign res.payload_valid = head.payload_valid;
    assign res.frame_end     = head.frame_end;
    assign res.status        = head.status;
    assign res.payload_count = head.payload_count;

    // A parser result only follows a byte accepted in the cycle before.
    `NFC_ASSERT_HOLDS(a_result_follows_beat, par_result.valid |-> $past(rx_fire), "parser result without a beat")
    // The queue never overflows: a result never arrives when no slot is left.
    `NFC_ASSERT_NEVER(a_no_overflow, push && !pop && ({1'b0, count_reg} == DEPTH_W), "result queue overflow")
    // A beat is either a payload byte or a frame end, never both.
    `NFC_ASSERT_NEVER(a_beat_kind, res.valid && res.payload_valid && res.frame_end, "payload beat marked as frame end")
    // Ready is withdrawn whenever the queue has been filled to the brim.
    `NFC_ASSERT_HOLDS(a_full_not_ready, ({1'b0, count_reg} == DEPTH_W) |-> !rx_ready_reg, "ready while queue full")

endmodule
